>>> rtl/mdos_pkg.sv
// Package for the motor drive output shaper.
// Holds field widths, register offsets, the register bank struct and the
// controller state, command and status types. Depends on nothing.
package mdos_pkg;

    // Field widths fixed by the item format.
    localparam int CH_W     = 2;
    localparam int CMD_W    = 16;
    localparam int TICK_W   = 16;
    localparam int ADDR_W   = 5;
    localparam int APB_DW   = 32;

    // Register indexes, one 32-bit word each.
    localparam logic [2:0] REG_OUT_MAX     = 3'd0;
    localparam logic [2:0] REG_RATE        = 3'd1;
    localparam logic [2:0] REG_DEAD_SPOT   = 3'd2;
    localparam logic [2:0] REG_DEAD_OFFSET = 3'd3;
    localparam logic [2:0] REG_SLOPE_INNER = 3'd4;
    localparam logic [2:0] REG_SLOPE_OUTER = 3'd5;

    // Register bank contents.
    typedef struct packed {
        logic [14:0] out_max;
        logic [15:0] rate_per_tick;
        logic [14:0] dead_spot;
        logic [14:0] dead_offset;
        logic [15:0] slope_inner;
        logic [15:0] slope_outer;
    } cfg_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_CLAMP,
        ST_MAP,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic limit;
        logic clamp;
        logic map;
        logic finish;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/mdos_cfg.sv
// Configuration register bank with an APB-style slave port.
// Depends on mdos_pkg for register offsets and the cfg_t struct.
module mdos_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mdos_pkg::ADDR_W-1:0]  paddr,
    input  logic [mdos_pkg::APB_DW-1:0]  pwdata,
    output logic [mdos_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output mdos_pkg::cfg_t               cfg
);
    import mdos_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes; offsets beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_max       <= 15'h7FFF;
            cfg_reg.rate_per_tick <= 16'hFFFF;
            cfg_reg.dead_spot     <= 15'd1;
            cfg_reg.dead_offset   <= 15'd0;
            cfg_reg.slope_inner   <= 16'd4096;
            cfg_reg.slope_outer   <= 16'd4096;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OUT_MAX:     cfg_reg.out_max       <= pwdata[14:0];
                REG_RATE:        cfg_reg.rate_per_tick <= pwdata[15:0];
                REG_DEAD_SPOT:   cfg_reg.dead_spot     <= pwdata[14:0];
                REG_DEAD_OFFSET: cfg_reg.dead_offset   <= pwdata[14:0];
                REG_SLOPE_INNER: cfg_reg.slope_inner   <= pwdata[15:0];
                REG_SLOPE_OUTER: cfg_reg.slope_outer   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_idx)
            REG_OUT_MAX:     prdata = {17'd0, cfg_reg.out_max};
            REG_RATE:        prdata = {16'd0, cfg_reg.rate_per_tick};
            REG_DEAD_SPOT:   prdata = {17'd0, cfg_reg.dead_spot};
            REG_DEAD_OFFSET: prdata = {17'd0, cfg_reg.dead_offset};
            REG_SLOPE_INNER: prdata = {16'd0, cfg_reg.slope_inner};
            REG_SLOPE_OUTER: prdata = {16'd0, cfg_reg.slope_outer};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> rtl/mdos_ctrl.sv
// Controller state machine for the output shaper.
// Sequences input load, slew limit, clamp, mapping and result commit.
// Depends on mdos_pkg for state, command and status types.
module mdos_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mdos_pkg::dp_stat_t  stat,
    output mdos_pkg::ctl_cmd_t  cmd
);
    import mdos_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The result goes out once the output register is free; the
                // next item may be taken in the same cycle.
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_LIMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mdos_dpath.sv
// Datapath of the output shaper: per-channel state, slew limit, clamp,
// deadband mapping with rounding and saturation, and the output register.
// Depends on mdos_pkg for widths and the command, status and config types.
module mdos_dpath #(
    parameter int CHANNELS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mdos_pkg::ctl_cmd_t           cmd,
    output mdos_pkg::dp_stat_t           stat,
    input  mdos_pkg::cfg_t               cfg,
    input  logic [mdos_pkg::CH_W-1:0]    in_channel,
    input  logic signed [mdos_pkg::CMD_W-1:0] in_raw,
    input  logic [mdos_pkg::TICK_W-1:0]  in_ticks,
    input  logic                         in_fault,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mdos_pkg::CH_W-1:0]    out_channel,
    output logic signed [mdos_pkg::CMD_W-1:0] out_drive,
    output logic                         out_rate_limited,
    output logic                         out_clipped,
    output logic                         out_held
);
    import mdos_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > CH_W) ? IDX_W : CH_W;

    // Per-channel state.
    logic signed [CMD_W-1:0] last_limited_reg [CHANNELS];
    logic signed [CMD_W-1:0] last_drive_reg   [CHANNELS];

    // Item registers.
    logic [CH_W-1:0]          ch_reg;
    logic signed [CMD_W-1:0]  raw_reg;
    logic [TICK_W-1:0]        ticks_reg;
    logic                     fault_reg;

    // Working registers.
    logic [31:0]              lim_reg;
    logic signed [16:0]       diff_reg;
    logic signed [CMD_W-1:0]  cmd_reg;
    logic                     rl_reg;
    logic                     cl_reg;
    logic [31:0]              prod_reg;
    logic                     neg_reg;
    logic [14:0]              offsel_reg;

    // Output register.
    logic                     out_valid_reg;
    logic [CH_W-1:0]          out_channel_reg;
    logic signed [CMD_W-1:0]  out_drive_reg;
    logic                     out_rl_reg;
    logic                     out_cl_reg;
    logic                     out_held_reg;

    logic [EXT_W-1:0]         ch_ext;
    logic [IDX_W-1:0]         idx;
    logic                     ch_ok;
    logic                     commit;
    logic signed [CMD_W-1:0]  prev;
    logic signed [CMD_W-1:0]  prev_drive;

    // Clamp stage signals.
    logic [16:0]              adiff;
    logic                     over;
    logic signed [16:0]       stepv;
    logic signed [16:0]       slew;
    logic signed [16:0]       cmd_pre;
    logic signed [16:0]       max_pos;
    logic signed [CMD_W-1:0]  cmd_clamped;
    logic                     clip;

    // Map stage signals.
    logic signed [16:0]       cmd_ext;
    logic signed [16:0]       ds_ext;
    logic                     outer_pos;
    logic                     outer_neg;
    logic signed [16:0]       xval;
    logic [16:0]              xabs;
    logic [15:0]              slope;

    // Finish stage signals.
    logic [31:0]              rnd;
    logic [20:0]              mag_sum;
    logic signed [CMD_W-1:0]  drv;
    logic signed [CMD_W-1:0]  res_drive;

    // Channel decode.
    assign ch_ext     = EXT_W'(ch_reg);
    assign idx        = ch_ext[IDX_W-1:0];
    assign ch_ok      = 32'(ch_reg) < 32'(CHANNELS);
    assign commit     = cmd.finish && ch_ok && !fault_reg;
    assign prev       = ch_ok ? last_limited_reg[idx] : '0;
    assign prev_drive = ch_ok ? last_drive_reg[idx] : '0;

    // Slew limit and magnitude clamp.
    always_comb
    begin
        adiff    = diff_reg[16] ? 17'(-diff_reg) : 17'(diff_reg);
        over     = {8'd0, adiff[15:0], 8'd0} > lim_reg;
        stepv    = {1'b0, lim_reg[23:8]};
        slew     = diff_reg[16] ? (17'(prev) - stepv) : (17'(prev) + stepv);
        cmd_pre  = over ? slew : 17'(raw_reg);
        max_pos  = {2'b00, cfg.out_max};
        clip     = 1'b0;
        if (cmd_pre > max_pos)
        begin
            cmd_clamped = max_pos[15:0];
            clip        = 1'b1;
        end
        else if (cmd_pre < -max_pos)
        begin
            cmd_clamped = 16'(-max_pos);
            clip        = 1'b1;
        end
        else
        begin
            cmd_clamped = cmd_pre[15:0];
        end
    end

    // Deadband branch selection and slope operand.
    always_comb
    begin
        cmd_ext   = 17'(cmd_reg);
        ds_ext    = {2'b00, cfg.dead_spot};
        outer_pos = cmd_ext > ds_ext;
        outer_neg = cmd_ext < -ds_ext;
        if (outer_pos)
        begin
            xval = cmd_ext - ds_ext;
        end
        else if (outer_neg)
        begin
            xval = cmd_ext + ds_ext;
        end
        else
        begin
            xval = cmd_ext;
        end
        xabs  = xval[16] ? 17'(-xval) : 17'(xval);
        slope = (outer_pos || outer_neg) ? cfg.slope_outer : cfg.slope_inner;
    end

    // Round the Q4.12 product, add the knee offset and saturate.
    always_comb
    begin
        rnd     = prod_reg + 32'd2048;
        mag_sum = 21'(rnd[31:12]) + 21'(offsel_reg);
        if (!neg_reg)
        begin
            drv = (mag_sum > 21'd32767) ? 16'sh7FFF : mag_sum[15:0];
        end
        else
        begin
            drv = (mag_sum > 21'd32768) ? 16'sh8000 : (16'd0 - mag_sum[15:0]);
        end
        if (!ch_ok)
        begin
            res_drive = '0;
        end
        else if (fault_reg)
        begin
            res_drive = prev_drive;
        end
        else
        begin
            res_drive = drv;
        end
    end

    // Item and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg    <= in_channel;
            raw_reg   <= in_raw;
            ticks_reg <= in_ticks;
            fault_reg <= in_fault;
        end
        if (cmd.limit)
        begin
            lim_reg  <= {16'd0, cfg.rate_per_tick} * {16'd0, ticks_reg};
            diff_reg <= 17'(raw_reg) - 17'(prev);
        end
        if (cmd.clamp)
        begin
            cmd_reg <= cmd_clamped;
            rl_reg  <= over;
            cl_reg  <= clip;
        end
        if (cmd.map)
        begin
            prod_reg   <= {16'd0, xabs[15:0]} * {16'd0, slope};
            neg_reg    <= xval[16];
            offsel_reg <= (outer_pos || outer_neg) ? cfg.dead_offset : 15'd0;
        end
    end

    // Per-channel state, updated only by a good item on a valid channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_limited_reg[i] <= '0;
                last_drive_reg[i]   <= '0;
            end
        end
        else if (commit)
        begin
            last_limited_reg[idx] <= cmd_reg;
            last_drive_reg[idx]   <= drv;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_channel_reg <= ch_reg;
            out_drive_reg   <= res_drive;
            out_rl_reg      <= ch_ok && !fault_reg && rl_reg;
            out_cl_reg      <= ch_ok && !fault_reg && cl_reg;
            out_held_reg    <= ch_ok && fault_reg;
        end
    end

    assign stat.out_free    = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_channel      = out_channel_reg;
    assign out_drive        = out_drive_reg;
    assign out_rate_limited = out_rl_reg;
    assign out_clipped      = out_cl_reg;
    assign out_held         = out_held_reg;

endmodule

>>> rtl/motor_drive_output_shaper_unit.sv
// Top level of the motor drive output shaper.
// Instantiates mdos_cfg, mdos_ctrl and mdos_dpath; depends on mdos_pkg.

// Each item carries one raw command for one motor channel. The command's change
// from that channel's last limited command is limited to rate_per_tick times
// elapsed_ticks (Q8.8), clamped to plus or minus out_max, then mapped through
// the deadband compensation curve (inner slope up to the knee, offset plus
// outer slope beyond it) with round-to-nearest and 16-bit saturation. A fault
// item returns the channel's last drive and changes no state; a channel at or
// above CHANNELS returns drive zero. One result per item. An item passes through
// the controller sequence (load and multiply, slew and clamp, slope multiply,
// round and commit); the next item is not taken until the last one commits,
// once the output register is free, and the result is registered at commit.
// The output register lets the next item start while a result waits. Registers
// lie at byte offsets 0x00 out_max, 0x04 rate_per_tick, 0x08 dead_spot, 0x0C
// dead_offset, 0x10 slope_inner, 0x14 slope_outer.
module motor_drive_output_shaper_unit #(
    parameter int CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] raw_command, [31:16] elapsed_ticks
    input  logic [2:0]  s_tuser,   // [1:0] channel, [2] fault
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] drive
    output logic [4:0]  m_tuser,   // [1:0] out_channel, [2] rate_limited,
                                   // [3] clipped, [4] held
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mdos_pkg::*;

    cfg_t                    cfg;
    ctl_cmd_t                cmd;
    dp_stat_t                stat;
    logic [CH_W-1:0]         out_channel;
    logic signed [CMD_W-1:0] out_drive;
    logic                    out_rl;
    logic                    out_cl;
    logic                    out_held;

    mdos_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mdos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mdos_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg              (cfg),
        .in_channel       (s_tuser[1:0]),
        .in_raw           (s_tdata[15:0]),
        .in_ticks         (s_tdata[31:16]),
        .in_fault         (s_tuser[2]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_channel      (out_channel),
        .out_drive        (out_drive),
        .out_rate_limited (out_rl),
        .out_clipped      (out_cl),
        .out_held         (out_held)
    );

    // Result packing.
    assign m_tdata = out_drive;
    assign m_tuser = {out_held, out_cl, out_rl, out_channel};

`ifndef SYNTH
    // An item occupies the controller sequence once accepted: no back-to-back accept.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted in consecutive cycles");

    // A held result never reports slew limiting or clamping.
    a_held_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> (!m_tuser[2] && !m_tuser[3]))
        else $error("held result carries limit flags");

    // A channel outside the configured range gives a zero, flag-free result.
    a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (32'(m_tuser[1:0]) >= 32'(CHANNELS)))
        |-> (m_tdata == 16'd0 && m_tuser[4:2] == 3'd0))
        else $error("out-of-range channel result not zero");
`endif

endmodule

>>> verif/mdos_drive_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the motor drive output shaper: tracks register writes, predicts
// every drive result from the accepted commands and checks the result stream in order.
// Depends on mdos_pkg for the register indexes and the register bank struct.
module mdos_drive_checker #(
    parameter int CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] raw_command, [31:16] elapsed_ticks
    input  logic [2:0]  s_tuser,   // [1:0] channel, [2] fault
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] drive
    input  logic [4:0]  m_tuser,   // [1:0] out_channel, [2] rate_limited,
                                   // [3] clipped, [4] held
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          commands_seen,
    output int          drives_seen,
    output int          slew_cuts,
    output int          clamp_hits,
    output int          fault_holds
);
    import mdos_pkg::*;

    // One result item as the block should produce it.
    typedef struct packed {
        logic [1:0]  chan;
        logic [15:0] drive;
        logic        slewed;
        logic        clamped;
        logic        held;
    } drive_result_t;

    // Shadow copy of the register bank and the per-channel history.
    cfg_t               shaper_cfg;
    logic signed [15:0] limited_cmd [CHANNELS];
    logic signed [15:0] held_drive  [CHANNELS];

    drive_result_t      expected_drives [$];
    drive_result_t      seen;
    drive_result_t      want;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] drive %0d: %s", $time, drives_seen, msg);
    endtask

    // Q4.12 product rounded to nearest, ties away from zero.
    function automatic longint round_q12(input longint slope, input longint x);
        longint prod;
        longint mag;
        prod = slope * x;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 2048) / 4096;
        return (prod < 0) ? -mag : mag;
    endfunction

    // Slew limit, clamp and deadband map for one command; updates the channel history.
    function automatic drive_result_t shape_command(input logic [1:0] ch,
            input logic signed [15:0] raw, input logic [15:0] ticks, input logic flt);
        drive_result_t r;
        longint prev;
        longint diff;
        longint adiff;
        longint allowed;
        longint tick_count;
        longint cmd;
        longint span;
        longint knee;
        longint offs;
        longint dv;
        r      = '0;
        r.chan = ch;
        if (int'(ch) >= CHANNELS)
            return r;
        if (flt)
        begin
            r.drive = held_drive[ch];
            r.held  = 1'b1;
            return r;
        end

        // Slew step: Q8.8 allowance, whole LSBs toward the raw command.
        prev       = limited_cmd[ch];
        cmd        = raw;
        diff       = cmd - prev;
        adiff      = (diff < 0) ? -diff : diff;
        allowed    = shaper_cfg.rate_per_tick;
        tick_count = ticks;
        allowed    = allowed * tick_count;
        if (adiff * 256 > allowed)
        begin
            cmd      = (diff > 0) ? prev + allowed / 256 : prev - allowed / 256;
            r.slewed = 1'b1;
        end

        // Magnitude clamp.
        span = shaper_cfg.out_max;
        if (cmd > span)
        begin
            cmd       = span;
            r.clamped = 1'b1;
        end
        else if (cmd < -span)
        begin
            cmd       = -span;
            r.clamped = 1'b1;
        end
        limited_cmd[ch] = cmd[15:0];

        // Deadband compensation curve, then 16-bit saturation.
        knee = shaper_cfg.dead_spot;
        offs = shaper_cfg.dead_offset;
        if (cmd > knee)
            dv = offs + round_q12(shaper_cfg.slope_outer, cmd - knee);
        else if (cmd < -knee)
            dv = -offs + round_q12(shaper_cfg.slope_outer, cmd + knee);
        else
            dv = round_q12(shaper_cfg.slope_inner, cmd);
        if (dv > 32767)
            dv = 32767;
        else if (dv < -32768)
            dv = -32768;
        held_drive[ch] = dv[15:0];
        r.drive        = dv[15:0];
        return r;
    endfunction

    // Watch the register port, the result stream and the command stream.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shaper_cfg.out_max       = 15'd32767;
            shaper_cfg.rate_per_tick = 16'd65535;
            shaper_cfg.dead_spot     = 15'd1;
            shaper_cfg.dead_offset   = 15'd0;
            shaper_cfg.slope_inner   = 16'd4096;
            shaper_cfg.slope_outer   = 16'd4096;
            for (int i = 0; i < CHANNELS; i++)
            begin
                limited_cmd[i] = '0;
                held_drive[i]  = '0;
            end
            expected_drives.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_OUT_MAX:     shaper_cfg.out_max       = pwdata[14:0];
                    REG_RATE:        shaper_cfg.rate_per_tick = pwdata[15:0];
                    REG_DEAD_SPOT:   shaper_cfg.dead_spot     = pwdata[14:0];
                    REG_DEAD_OFFSET: shaper_cfg.dead_offset   = pwdata[14:0];
                    REG_SLOPE_INNER: shaper_cfg.slope_inner   = pwdata[15:0];
                    REG_SLOPE_OUTER: shaper_cfg.slope_outer   = pwdata[15:0];
                    default: ;
                endcase
            end

            // A result can only belong to a command accepted at an earlier edge.
            if (m_tvalid && m_tready)
            begin
                seen = drive_result_t'({m_tuser[1:0], m_tdata, m_tuser[2], m_tuser[3],
                                        m_tuser[4]});
                drives_seen++;
                if (expected_drives.size() == 0)
                    report_mismatch($sformatf("result on channel %0d with nothing expected",
                                              seen.chan));
                else
                begin
                    want = expected_drives.pop_front();
                    if (seen.chan !== want.chan)
                        report_mismatch($sformatf("out_channel %0d, expected %0d",
                                                  seen.chan, want.chan));
                    if (seen.drive !== want.drive)
                        report_mismatch($sformatf("drive %0d, expected %0d",
                                                  $signed(seen.drive), $signed(want.drive)));
                    if (seen.slewed !== want.slewed)
                        report_mismatch($sformatf("rate_limited %b, expected %b",
                                                  seen.slewed, want.slewed));
                    if (seen.clamped !== want.clamped)
                        report_mismatch($sformatf("clipped %b, expected %b",
                                                  seen.clamped, want.clamped));
                    if (seen.held !== want.held)
                        report_mismatch($sformatf("held %b, expected %b",
                                                  seen.held, want.held));
                end
            end

            if (s_tvalid && s_tready)
            begin
                want = shape_command(s_tuser[1:0], s_tdata[15:0], s_tdata[31:16], s_tuser[2]);
                expected_drives.push_back(want);
                commands_seen++;
                slew_cuts   += want.slewed;
                clamp_hits  += want.clamped;
                fault_holds += want.held;
            end
            pending = expected_drives.size();
        end
    end

endmodule

>>> verif/tb_motor_drive_output_shaper_unit.sv
`timescale 1ns / 1ps
// Testbench top for the motor drive output shaper: drives commands, register writes
// and result back-pressure, and gives the verdict. Depends on mdos_pkg,
// motor_drive_output_shaper_unit and mdos_drive_checker.
module tb_motor_drive_output_shaper_unit;
    import mdos_pkg::*;

    localparam int SHAPER_CHANNELS = 4;
    localparam int STALL_LIMIT     = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int commands_seen;
    int drives_seen;
    int slew_cuts;
    int clamp_hits;
    int fault_holds;

    bit   src_idling;
    bit   sink_idling;
    int   sink_wait;
    int   quiet_cycles;
    int   settings_used;
    cfg_t phase_cfg;

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    motor_drive_output_shaper_unit #(
        .CHANNELS (SHAPER_CHANNELS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mdos_drive_checker #(
        .CHANNELS (SHAPER_CHANNELS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .commands_seen (commands_seen),
        .drives_seen   (drives_seen),
        .slew_cuts     (slew_cuts),
        .clamp_hits    (clamp_hits),
        .fault_holds   (fault_holds)
    );

    // Result back-pressure: after each taken result, stall for a random number of cycles while sink_idling is set.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sink_wait = sink_idling ? $urandom_range(0, 8) : 0;
    end

    always @(negedge clk)
    begin
        if (rst_n && sink_wait > 0)
        begin
            m_tready <= 1'b0;
            sink_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: ends the run when nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d idle cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Sends one command item; entered and left at a falling edge.
    task automatic send_item(input logic [1:0] ch, input logic [15:0] raw,
            input logic [15:0] ticks, input logic flt);
        int unsigned gap;
        gap = src_idling ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ticks, raw};
        s_tuser  <= {flt, ch};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Holds off new commands until every result is back and the pipeline is quiet.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Register write: a setup phase, an access phase held until pready, then a quiet bus.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_shaper(input cfg_t c);
        wait_for_drain();
        write_register(REG_OUT_MAX,     32'(c.out_max));
        write_register(REG_RATE,        32'(c.rate_per_tick));
        write_register(REG_DEAD_SPOT,   32'(c.dead_spot));
        write_register(REG_DEAD_OFFSET, 32'(c.dead_offset));
        write_register(REG_SLOPE_INNER, 32'(c.slope_inner));
        write_register(REG_SLOPE_OUTER, 32'(c.slope_outer));
        phase_cfg = c;
        settings_used++;
    endtask

    // Register value: all zeros or all ones when forced, else zero, full scale,
    // a typical value or a random one.
    function automatic logic [15:0] pick_setting(input logic [15:0] full,
            input logic [15:0] typical, input int forced);
        int unsigned sel;
        sel = (forced < 2) ? forced : $urandom_range(0, 5);
        case (sel)
            0:       return 16'd0;
            1:       return full;
            2:       return typical;
            default: return 16'($urandom) & full;
        endcase
    endfunction

    initial
    begin
        cfg_t        next_cfg;
        int          phase;
        int          n;
        int unsigned pick;
        int          mag;
        logic [15:0] raw;
        logic [15:0] ticks;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        src_idling  = 1'b1;
        sink_idling = 1'b1;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: unit slopes with no offset, knee at one, no clamp below full scale.
        send_item(2'd0, 16'h7FFF, 16'hFFFF, 1'b0);
        send_item(2'd1, 16'h8000, 16'hFFFF, 1'b0);
        send_item(2'd2, 16'd12345, 16'd0, 1'b0);
        send_item(2'd3, -16'sd20000, 16'd1, 1'b0);
        send_item(2'd0, 16'd0, 16'hFFFF, 1'b1);
        send_item(2'd3, -16'sd1, 16'hFFFF, 1'b0);
        send_item(2'd1, 16'd1, 16'd2, 1'b0);
        send_item(2'd2, 16'h8000, 16'hFFFF, 1'b1);

        // Steep outer slope with a high offset: saturation, ties at the inner slope,
        // and a slew cut that still ends up clamped.
        program_shaper(cfg_t'{15'd20000, 16'd256, 15'd100, 15'd32767, 16'd2048, 16'd65535});
        send_item(2'd0, 16'd1, 16'd1000, 1'b0);
        send_item(2'd0, 16'd1, 16'hFFFF, 1'b0);
        send_item(2'd0, -16'sd1, 16'hFFFF, 1'b0);
        send_item(2'd0, 16'd100, 16'hFFFF, 1'b0);
        send_item(2'd0, 16'd101, 16'hFFFF, 1'b0);
        send_item(2'd0, -16'sd101, 16'hFFFF, 1'b0);
        send_item(2'd1, 16'd3, 16'd0, 1'b0);

        // Knee at zero: the outer branch takes every nonzero command.
        program_shaper(cfg_t'{15'd32767, 16'd65535, 15'd0, 15'd500, 16'd65535, 16'd0});
        send_item(2'd2, 16'd0, 16'hFFFF, 1'b0);
        send_item(2'd2, 16'd1, 16'hFFFF, 1'b0);
        send_item(2'd2, -16'sd1, 16'hFFFF, 1'b0);
        send_item(2'd3, 16'h8000, 16'hFFFF, 1'b0);
        send_item(2'd3, 16'h7FFF, 16'd0, 1'b0);

        // Random phases: all-minimum and all-maximum settings first, then mixed ones.
        for (phase = 0; phase < 12; phase++)
        begin
            next_cfg.out_max       = 15'(pick_setting(16'h7FFF, 16'd30000, phase));
            next_cfg.rate_per_tick = pick_setting(16'hFFFF, 16'd4096, phase);
            next_cfg.dead_spot     = 15'(pick_setting(16'h7FFF, 16'd200, phase));
            next_cfg.dead_offset   = 15'(pick_setting(16'h7FFF, 16'd1500, phase));
            next_cfg.slope_inner   = pick_setting(16'hFFFF, 16'd4096, phase);
            next_cfg.slope_outer   = pick_setting(16'hFFFF, 16'd3900, phase);
            program_shaper(next_cfg);
            src_idling  = (phase % 3) != 2;
            sink_idling = (phase % 4) != 2;

            for (n = 0; n < 153; n++)
            begin
                // Commands: extremes, random words, or magnitudes near the knee or clamp.
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    raw = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                else if (pick < 5)
                    raw = 16'($urandom);
                else
                begin
                    mag = (pick < 8) ? int'(phase_cfg.dead_spot) : int'(phase_cfg.out_max);
                    mag = mag + int'($urandom_range(0, 8)) - 4;
                    if (mag < 0)
                        mag = 0;
                    if (mag > 32767)
                        mag = 32767;
                    raw = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                end

                // Mostly short intervals so the slew limit bites.
                case ($urandom_range(0, 9))
                    0:       ticks = 16'hFFFF;
                    1, 2:    ticks = 16'($urandom);
                    3, 4:    ticks = 16'($urandom_range(0, 1023));
                    default: ticks = 16'($urandom_range(0, 8));
                endcase
                send_item(2'($urandom_range(0, 3)), raw, ticks, $urandom_range(0, 9) == 0);
            end
        end

        wait_for_drain();
        repeat (10) @(negedge clk);
        $display("Sent %0d commands under %0d register settings plus reset values; %0d results.",
                 commands_seen, settings_used, drives_seen);
        $display("Slew limit cut %0d, clamp acted %0d, fault held %0d of them.",
                 slew_cuts, clamp_hits, fault_holds);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mdos_pkg.sv
rtl/mdos_cfg.sv
rtl/mdos_ctrl.sv
rtl/mdos_dpath.sv
rtl/motor_drive_output_shaper_unit.sv
verif/mdos_drive_checker.sv
verif/tb_motor_drive_output_shaper_unit.sv
